// ===== src/uart_ring_fifo_xon_xoff_top_macros.svh =====
// Assertion helpers shared by the ring engine modules
`ifndef UART_RING_FIFO_XON_XOFF_TOP_MACROS_SVH
`define UART_RING_FIFO_XON_XOFF_TOP_MACROS_SVH

// same-cycle implication
`define UFX_ASSERT_IMPLY(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UFX_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

// invariant
`define UFX_ASSERT_ALWAYS(label, ck, rn, cond, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error(msg);

`endif

// ===== src/ufx_pkg.sv =====
package ufx_pkg;

    localparam int DEPTH  = 256;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = 8;
    localparam int BYTE_W = 8;
    localparam int CMP_W  = (PTR_W > FILL_W) ? PTR_W : FILL_W;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FLOW_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_XOFF_LEVEL  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_XON_LEVEL   = CFG_IDX_W'(2);

    localparam logic [BYTE_W-1:0] XON_CHAR  = 8'd17;
    localparam logic [BYTE_W-1:0] XOFF_CHAR = 8'd19;

    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'((DEPTH - 1) % (1 << FILL_W));

    localparam logic [FILL_W-1:0] XOFF_LEVEL_RST = 8'd192;
    localparam logic [FILL_W-1:0] XON_LEVEL_RST  = 8'd128;

    typedef enum logic [1:0] {
        EV_RX_BYTE    = 2'd0,
        EV_HOST_READ  = 2'd1,
        EV_HOST_WRITE = 2'd2,
        EV_TX_READY   = 2'd3
    } event_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } back_state_t;

    typedef struct packed {
        event_t              ev;
        logic [BYTE_W-1:0]   data;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   host_byte;
        logic                host_byte_valid;
        logic                write_accepted;
        logic                rx_dropped;
        logic [BYTE_W-1:0]   line_byte;
        logic                line_byte_valid;
        logic [FILL_W-1:0]   fill_count;
    } res_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ring_count(input logic [PTR_W-1:0] head,
                                                    input logic [PTR_W-1:0] tail);
        return (head >= tail) ? head - tail : head + PTR_W'(DEPTH) - tail;
    endfunction

    function automatic logic [FILL_W-1:0] fill8(input logic [PTR_W-1:0] c);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(c);
        return wide[FILL_W-1:0];
    endfunction

endpackage

// ===== src/ufx_ram.sv =====
module ufx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ufx_front.sv =====
`include "uart_ring_fifo_xon_xoff_top_macros.svh"

module ufx_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [1:0]    kind,
    input  logic [7:0]    data_byte,
    output logic          cmd_valid,
    output ufx_pkg::cmd_t cmd,
    input  logic          take
);

    import ufx_pkg::*;

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push_ok;
    cmd_t              decoded;

    assign full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push_ok   = push && !full;

    // classify the request; data matters only for line and host bytes
    always_comb
    begin
        decoded = '0;
        case (kind)
            EV_RX_BYTE:
            begin
                decoded.ev   = EV_RX_BYTE;
                decoded.data = data_byte;
            end
            EV_HOST_READ:
            begin
                decoded.ev = EV_HOST_READ;
            end
            EV_HOST_WRITE:
            begin
                decoded.ev   = EV_HOST_WRITE;
                decoded.data = data_byte;
            end
            default:
            begin
                decoded.ev = EV_TX_READY;
            end
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push_ok, take})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

    `UFX_ASSERT_ALWAYS(a_q_cnt_range, clk, rst_n, cnt_reg <= QCNT_W'(QDEPTH), "queue overfilled")
    `UFX_ASSERT_ALWAYS(a_q_ptr_cnt, clk, rst_n, (wr_ptr_reg != rd_ptr_reg) == (cnt_reg == QCNT_W'(1)), "queue pointers disagree with count")

endmodule

// ===== src/ufx_back.sv =====
`include "uart_ring_fifo_xon_xoff_top_macros.svh"

module ufx_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    input  ufx_pkg::cmd_t                    cmd,
    output logic                             take,
    input  logic                             cfg_valid,
    input  logic [ufx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                       cfg_data,
    output logic                             res_valid,
    output ufx_pkg::res_t                    res,
    input  logic                             pop
);

    import ufx_pkg::*;

    back_state_t       state_reg, state_next;
    logic              done;

    logic [PTR_W-1:0]  rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [PTR_W-1:0]  tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic              peer_allowed_reg, peer_allowed_next;
    logic              peer_stopped_reg, peer_stopped_next;
    logic              control_pending_reg, control_pending_next;
    logic              transmit_request_reg, transmit_request_next;

    logic              flow_enable_reg, flow_enable_next;
    logic [FILL_W-1:0] xoff_level_reg, xoff_level_next;
    logic [FILL_W-1:0] xon_level_reg, xon_level_next;

    logic              out_valid_reg, out_valid_next;
    res_t              out_reg;
    res_t              result;

    logic              rx_we, tx_we;
    logic [BYTE_W-1:0] rx_rdata, tx_rdata;

    logic [PTR_W-1:0]  rx_nx, tx_nx, rx_cnt, tx_cnt, rx_cnt_after, tx_cnt_after;
    logic              rx_full, tx_full, rx_empty, tx_empty;
    logic              lvl_xoff, lvl_xon;

    ufx_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_head_reg),
        .wdata (cmd.data),
        .raddr (rx_tail_reg),
        .rdata (rx_rdata)
    );

    ufx_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_head_reg),
        .wdata (cmd.data),
        .raddr (tx_tail_reg),
        .rdata (tx_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || pop)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        done = 1'b0;
        case (state_reg)
            ST_EXEC: done = !out_valid_reg || pop;
            default: done = 1'b0;
        endcase
    end

    assign take = done;

    assign rx_nx        = ptr_inc(rx_head_reg);
    assign tx_nx        = ptr_inc(tx_head_reg);
    assign rx_full      = (rx_nx == rx_tail_reg);
    assign tx_full      = (tx_nx == tx_tail_reg);
    assign rx_empty     = (rx_head_reg == rx_tail_reg);
    assign tx_empty     = (tx_head_reg == tx_tail_reg);
    assign rx_cnt       = ring_count(rx_head_reg, rx_tail_reg);
    assign tx_cnt       = ring_count(tx_head_reg, tx_tail_reg);
    assign rx_cnt_after = ring_count(rx_nx, rx_tail_reg);
    assign tx_cnt_after = ring_count(tx_nx, tx_tail_reg);
    assign lvl_xoff     = CMP_W'(rx_cnt) >= CMP_W'(xoff_level_reg);
    assign lvl_xon      = CMP_W'(rx_cnt) <= CMP_W'(xon_level_reg);

    always_comb
    begin
        rx_head_next          = rx_head_reg;
        rx_tail_next          = rx_tail_reg;
        tx_head_next          = tx_head_reg;
        tx_tail_next          = tx_tail_reg;
        peer_allowed_next     = peer_allowed_reg;
        peer_stopped_next     = peer_stopped_reg;
        control_pending_next  = control_pending_reg;
        transmit_request_next = transmit_request_reg;
        rx_we                 = 1'b0;
        tx_we                 = 1'b0;
        result                = '0;
        if (done)
        begin
            case (cmd.ev)
                EV_RX_BYTE:
                begin
                    if (!rx_full)
                    begin
                        rx_we             = 1'b1;
                        rx_head_next      = rx_nx;
                        result.fill_count = fill8(rx_cnt_after);
                    end
                    else
                    begin
                        result.rx_dropped = 1'b1;
                        result.fill_count = FULL_FILL;
                    end
                end
                EV_HOST_READ:
                begin
                    if (!rx_empty)
                    begin
                        result.fill_count      = fill8(rx_cnt);
                        result.host_byte       = rx_rdata;
                        result.host_byte_valid = 1'b1;
                        rx_tail_next           = ptr_inc(rx_tail_reg);
                        if (flow_enable_reg)
                        begin
                            if (lvl_xoff)
                            begin
                                peer_allowed_next = 1'b0;
                                if (!peer_stopped_reg)
                                begin
                                    peer_stopped_next     = 1'b1;
                                    control_pending_next  = 1'b1;
                                    transmit_request_next = 1'b1;
                                end
                            end
                            else if (lvl_xon)
                            begin
                                peer_stopped_next = 1'b0;
                                if (!peer_allowed_reg)
                                begin
                                    peer_allowed_next     = 1'b1;
                                    control_pending_next  = 1'b1;
                                    transmit_request_next = 1'b1;
                                end
                            end
                        end
                    end
                end
                EV_HOST_WRITE:
                begin
                    if (!tx_full)
                    begin
                        tx_we                 = 1'b1;
                        tx_head_next          = tx_nx;
                        result.fill_count     = fill8(tx_cnt_after);
                        result.write_accepted = 1'b1;
                        if (tx_cnt_after == PTR_W'(1))
                        begin
                            transmit_request_next = 1'b1;
                        end
                    end
                    else
                    begin
                        result.fill_count = FULL_FILL;
                    end
                end
                default:
                begin
                    if (transmit_request_reg)
                    begin
                        if (control_pending_reg)
                        begin
                            result.line_byte       = peer_allowed_reg ? XON_CHAR : XOFF_CHAR;
                            result.line_byte_valid = 1'b1;
                            result.fill_count      = fill8(tx_cnt);
                            control_pending_next   = 1'b0;
                        end
                        else if (!tx_empty)
                        begin
                            result.line_byte       = tx_rdata;
                            result.line_byte_valid = 1'b1;
                            result.fill_count      = fill8(tx_cnt);
                            tx_tail_next           = ptr_inc(tx_tail_reg);
                        end
                        else
                        begin
                            transmit_request_next = 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        flow_enable_next = flow_enable_reg;
        xoff_level_next  = xoff_level_reg;
        xon_level_next   = xon_level_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FLOW_ENABLE: flow_enable_next = cfg_data[0];
                REG_XOFF_LEVEL:  xoff_level_next  = cfg_data;
                REG_XON_LEVEL:   xon_level_next   = cfg_data;
                default:         flow_enable_next = flow_enable_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            rx_head_reg          <= '0;
            rx_tail_reg          <= '0;
            tx_head_reg          <= '0;
            tx_tail_reg          <= '0;
            peer_allowed_reg     <= 1'b1;
            peer_stopped_reg     <= 1'b0;
            control_pending_reg  <= 1'b0;
            transmit_request_reg <= 1'b0;
            flow_enable_reg      <= 1'b1;
            xoff_level_reg       <= XOFF_LEVEL_RST;
            xon_level_reg        <= XON_LEVEL_RST;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg            <= state_next;
            rx_head_reg          <= rx_head_next;
            rx_tail_reg          <= rx_tail_next;
            tx_head_reg          <= tx_head_next;
            tx_tail_reg          <= tx_tail_next;
            peer_allowed_reg     <= peer_allowed_next;
            peer_stopped_reg     <= peer_stopped_next;
            control_pending_reg  <= control_pending_next;
            transmit_request_reg <= transmit_request_next;
            flow_enable_reg      <= flow_enable_next;
            xoff_level_reg       <= xoff_level_next;
            xon_level_reg        <= xon_level_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= result;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    `UFX_ASSERT_IMPLY(a_pending_needs_req, clk, rst_n, control_pending_reg, transmit_request_reg, "control char pending without transmit request")
    `UFX_ASSERT_IMPLY(a_stopped_not_allowed, clk, rst_n, peer_stopped_reg, !peer_allowed_reg, "peer stopped and allowed at once")
    `UFX_ASSERT_NEXT(a_done_loads_result, clk, rst_n, done, out_valid_reg, "finished request left no result")

endmodule

// ===== src/uart_ring_fifo_xon_xoff_top.sv =====
// Channel   | Handshake             | Payload
// ----------+-----------------------+-----------------------------------------
// request   | push / full           | kind, data_byte
// result    | empty / pop           | host_byte, host_byte_valid, write_accepted,
//           |                       | rx_dropped, line_byte, line_byte_valid,
//           |                       | fill_count
// config    | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A request first reads the ring memory at the tail pointer (back end in ST_IDLE),
// then updates pointers, writes the ring and loads the result in ST_EXEC.
// Requests queue two deep in front; results wait in a one-entry output register,
// and a result not yet popped holds the back end in ST_EXEC.
// Reset clears pointers, presets flow flags and config; ring RAMs are not cleared.
// The config port is always ready.
module uart_ring_fifo_xon_xoff_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    kind,
    input  logic [7:0]                    data_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    host_byte,
    output logic                          host_byte_valid,
    output logic                          write_accepted,
    output logic                          rx_dropped,
    output logic [7:0]                    line_byte,
    output logic                          line_byte_valid,
    output logic [7:0]                    fill_count,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ufx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);

    import ufx_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic take;
    logic res_valid;
    res_t res;

    ufx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .data_byte (data_byte),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .take      (take)
    );

    ufx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .take      (take),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res),
        .pop       (pop && res_valid)
    );

    assign cfg_ready       = 1'b1;
    assign empty           = !res_valid;
    assign host_byte       = res.host_byte;
    assign host_byte_valid = res.host_byte_valid;
    assign write_accepted  = res.write_accepted;
    assign rx_dropped      = res.rx_dropped;
    assign line_byte       = res.line_byte;
    assign line_byte_valid = res.line_byte_valid;
    assign fill_count      = res.fill_count;

endmodule
